// ===== design/ubsw_pkg.sv =====
package ubsw_pkg;

	localparam int WORD_BYTES   = 8;
	localparam int MAX_LANES    = 8;
	localparam int SCRATCH_BANK = 15;
	localparam int BYTE_BITS    = 8;

	localparam int ADDR_W  = 32;
	localparam int DATA_W  = 64;
	localparam int BE_W    = 8;
	localparam int COUNT_W = 4;
	localparam int WB_BITS = $clog2(WORD_BYTES);
	localparam int Q_DEPTH = 2;

	typedef struct packed {
		logic [15:0] row;
		logic [15:0] col;
		logic [15:0] channel_begin;
		logic [7:0]  lane_count;
		logic [63:0] packed_data;
	} tile_t;

	typedef struct packed {
		logic        rejected;
		logic [31:0] word_address;
		logic        to_scratch;
		logic [7:0]  bank_out;
		logic [7:0]  byte_enable;
		logic [63:0] write_data;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [31:0] base;
		logic [15:0] height;
		logic [15:0] width;
		logic [15:0] channels;
		logic [15:0] phys_channels;
		logic [15:0] channel_offset;
		logic [7:0]  bank;
	} cfg_t;

	// classified item handed from the front to the back
	typedef struct packed {
		logic               rejected;
		logic [ADDR_W-1:0]  start_addr;
		logic [COUNT_W-1:0] lanes;
		logic [DATA_W-1:0]  data;
	} work_t;

	typedef enum logic {
		BK_FIRST,
		BK_SECOND
	} back_state_t;

	// ones in the low n bytes, n clamped to the word
	function automatic logic [BE_W-1:0] low_mask(input logic [COUNT_W-1:0] n);
		logic [BE_W-1:0] m;
		if (n >= COUNT_W'(BE_W)) begin
			m = '1;
		end else begin
			m = (BE_W'(1) << n) - BE_W'(1);
		end
		return m;
	endfunction

	function automatic logic [DATA_W-1:0] byte_expand(input logic [BE_W-1:0] be);
		logic [DATA_W-1:0] d;
		for (int i = 0; i < BE_W; i++) begin
			d[i*BYTE_BITS +: BYTE_BITS] = {BYTE_BITS{be[i]}};
		end
		return d;
	endfunction

endpackage

// ===== design/ubsw_front.sv =====
module ubsw_front import ubsw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  push,
	input  tile_t tile,
	output logic  full,
	input  logic  q_full,
	output logic  q_push,
	output work_t q_entry
);

	logic adv;
	logic rej_in;

	logic v_s1, v_s2, v_s3;
	logic rej_s1, rej_s2, rej_s3;
	logic [15:0] row_s1, col_s1, cb_s1;
	logic [COUNT_W-1:0] lanes_s1, lanes_s2, lanes_s3;
	logic [DATA_W-1:0] data_s1, data_s2, data_s3;
	logic [ADDR_W-1:0] pix_s2, off_s2, prod_s3, off_s3;
	logic [15:0] phys;

	// whole pipeline moves together; it stops only when the last stage cannot drain
	assign adv  = !(v_s3 && q_full);
	assign full = !adv;

	assign rej_in = (tile.lane_count == 8'd0) ||
	                (tile.lane_count > 8'(MAX_LANES)) ||
	                (tile.row >= cfg.height) ||
	                (tile.col >= cfg.width) ||
	                (({1'b0, tile.channel_begin} + 17'(tile.lane_count)) >
	                 {1'b0, cfg.channels});

	assign phys = (cfg.phys_channels == 16'd0) ? cfg.channels : cfg.phys_channels;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rej_s1   <= rej_in;
			row_s1   <= tile.row;
			col_s1   <= tile.col;
			cb_s1    <= tile.channel_begin;
			lanes_s1 <= tile.lane_count[COUNT_W-1:0];
			data_s1  <= tile.packed_data & byte_expand(low_mask(COUNT_W'(MAX_LANES)));

			rej_s2   <= rej_s1;
			pix_s2   <= ({16'd0, row_s1} * {16'd0, cfg.width}) + {16'd0, col_s1};
			off_s2   <= cfg.base + {16'd0, cfg.channel_offset} + {16'd0, cb_s1};
			lanes_s2 <= lanes_s1;
			data_s2  <= data_s1;

			rej_s3   <= rej_s2;
			prod_s3  <= pix_s2 * {16'd0, phys};
			off_s3   <= off_s2;
			lanes_s3 <= lanes_s2;
			data_s3  <= data_s2;
		end
	end

	assign q_push             = v_s3 && adv;
	assign q_entry.rejected   = rej_s3;
	assign q_entry.start_addr = prod_s3 + off_s3;
	assign q_entry.lanes      = lanes_s3;
	assign q_entry.data       = data_s3;

endmodule

// ===== design/ubsw_queue.sv =====
module ubsw_queue import ubsw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  work_t wr_entry,
	input  logic  pop,
	output logic  head_valid,
	output work_t head,
	output logic  full
);

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	work_t mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign head_valid = (cnt_q != '0);
	assign full       = (cnt_q == CNT_W'(Q_DEPTH));
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

// ===== design/ubsw_back.sv =====
module ubsw_back import ubsw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    head_valid,
	input  work_t   head,
	output logic    q_pop,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	localparam logic [COUNT_W-1:0] WB_CNT = COUNT_W'(WORD_BYTES);

	back_state_t state_q, state_d;
	logic        out_v_q;
	result_t     out_q;
	result_t     res;
	logic        out_ld;

	logic [COUNT_W-1:0] byte0, room, first_n, rem, rem_n;
	logic               split;
	logic [ADDR_W-1:0]  word0, word1;
	logic [BE_W-1:0]    be0, be1;
	logic [DATA_W-1:0]  data0, data1;

	assign byte0   = COUNT_W'(head.start_addr[WB_BITS-1:0]);
	assign room    = WB_CNT - byte0;
	assign split   = head.lanes > room;
	assign first_n = split ? room : head.lanes;
	assign rem     = head.lanes - room;
	assign rem_n   = (rem > WB_CNT) ? WB_CNT : rem;

	assign word0 = {head.start_addr[ADDR_W-1:WB_BITS], {WB_BITS{1'b0}}};
	assign word1 = word0 + ADDR_W'(WORD_BYTES);

	assign be0   = (low_mask(first_n) << byte0) & low_mask(WB_CNT);
	assign data0 = (head.data << ({3'd0, byte0} * 7'(BYTE_BITS))) & byte_expand(be0);
	// second part starts at byte 0 of the next word
	assign be1   = low_mask(rem_n);
	assign data1 = (head.data >> ({3'd0, room} * 7'(BYTE_BITS))) & byte_expand(be1);

	assign empty  = !out_v_q;
	assign out_ld = head_valid && (!out_v_q || pop);

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		res     = '0;
		unique case (state_q)
			BK_FIRST: begin
				if (head.rejected) begin
					res.rejected = 1'b1;
					res.last     = 1'b1;
					q_pop        = out_ld;
				end else begin
					res.word_address = word0;
					res.to_scratch   = (cfg.bank == 8'(SCRATCH_BANK));
					res.bank_out     = cfg.bank;
					res.byte_enable  = be0;
					res.write_data   = data0;
					res.last         = !split;
					q_pop            = out_ld && !split;
					if (out_ld && split) begin
						state_d = BK_SECOND;
					end
				end
			end
			BK_SECOND: begin
				res.word_address = word1;
				res.to_scratch   = (cfg.bank == 8'(SCRATCH_BANK));
				res.bank_out     = cfg.bank;
				res.byte_enable  = be1;
				res.write_data   = data1;
				res.last         = 1'b1;
				q_pop            = out_ld;
				if (out_ld) begin
					state_d = BK_FIRST;
				end
			end
			default: begin
				state_d = BK_FIRST;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_FIRST;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_ld) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			out_q <= res;
		end
	end

	assign result = out_q;

endmodule

// ===== design/unaligned_byte_slice_writer_unit.sv =====
// Unaligned byte slice writer.
// Input queue side: tile (row, col, channel_begin, lane_count, packed_data) is taken
// at a clock edge with push high and full low. Output queue side: while empty is low
// the oldest word write sits on result; pop high at an edge takes it.
// Each tile gives one result: a rejected marker, or a byte-enabled aligned word
// write, or two when its bytes cross a word boundary; last marks the final one.
// Configuration goes through the APB port (registers at 4*index, pready always
// high); the user writes it only while the block is idle, which it does not enforce.
// The first result of a tile passes three address stages holding two multipliers,
// a two-entry queue and the output register. Throughput: one tile per cycle while
// tiles fit in one word and pop keeps up; a split tile holds the single output
// register for both of its words before the next tile can load it.
// When pop stays low the output register holds, the queue fills, and full rises
// once the address pipeline has its last stage loaded; nothing is dropped.
// Reset clears the pipeline, queue and output valid state and sets all
// configuration registers to zero.
module unaligned_byte_slice_writer_unit import ubsw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	input  tile_t       tile,
	output logic        full,
	input  logic        pop,
	output logic        empty,
	output result_t     result
);

	localparam logic [2:0] REG_BASE     = 3'd0;
	localparam logic [2:0] REG_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_WIDTH    = 3'd2;
	localparam logic [2:0] REG_CHANNELS = 3'd3;
	localparam logic [2:0] REG_PHYS     = 3'd4;
	localparam logic [2:0] REG_CH_OFF   = 3'd5;
	localparam logic [2:0] REG_BANK     = 3'd6;

	cfg_t  cfg_q;
	logic  wr_en;
	logic  q_push, q_pop, q_full, head_valid;
	work_t q_entry, head;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_BASE:     cfg_q.base           <= pwdata;
				REG_HEIGHT:   cfg_q.height         <= pwdata[15:0];
				REG_WIDTH:    cfg_q.width          <= pwdata[15:0];
				REG_CHANNELS: cfg_q.channels       <= pwdata[15:0];
				REG_PHYS:     cfg_q.phys_channels  <= pwdata[15:0];
				REG_CH_OFF:   cfg_q.channel_offset <= pwdata[15:0];
				REG_BANK:     cfg_q.bank           <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_BASE:     prdata = cfg_q.base;
			REG_HEIGHT:   prdata = {16'd0, cfg_q.height};
			REG_WIDTH:    prdata = {16'd0, cfg_q.width};
			REG_CHANNELS: prdata = {16'd0, cfg_q.channels};
			REG_PHYS:     prdata = {16'd0, cfg_q.phys_channels};
			REG_CH_OFF:   prdata = {16'd0, cfg_q.channel_offset};
			REG_BANK:     prdata = {24'd0, cfg_q.bank};
			default:      prdata = '0;
		endcase
	end

	ubsw_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.push    (push),
		.tile    (tile),
		.full    (full),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_entry)
	);

	ubsw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.wr_entry   (q_entry),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head       (head),
		.full       (q_full)
	);

	ubsw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

	a_reject_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.rejected) |->
		(result.last && result.byte_enable == '0 && result.write_data == '0))
		else $error("rejected item carries write fields");

	a_write_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.rejected) |-> (result.byte_enable != '0))
		else $error("word write with no byte enabled");

	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.word_address[WB_BITS-1:0] == '0))
		else $error("word address not aligned");

	a_split_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !result.last) |=>
		(!empty && !result.rejected && result.last && result.byte_enable[0]))
		else $error("second part of split write missing");

endmodule

// ===== bench/unaligned_byte_slice_writer_unit_tb.sv =====
module unaligned_byte_slice_writer_unit_tb;
	import ubsw_pkg::*;

	typedef enum int {
		REG_BASE,
		REG_HEIGHT,
		REG_WIDTH,
		REG_CHANNELS,
		REG_PHYS,
		REG_OFFSET,
		REG_BANK
	} reg_idx_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        push;
	tile_t       tile;
	logic        full;
	logic        pop;
	logic        empty;
	result_t     result;

	// destination tensor as the block should currently see it
	logic [31:0] dst_base;
	logic [15:0] dst_height;
	logic [15:0] dst_width;
	logic [15:0] dst_channels;
	logic [15:0] dst_phys;
	logic [15:0] dst_offset;
	logic [7:0]  dst_bank;

	tile_t   pending_tiles[$];
	result_t expected_writes[$];
	result_t want;

	int errors = 0;
	int tx_gap = 0;
	int rx_gap = 0;
	int hold_left = 0;
	int hold_req = 0;
	int hold_seen = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	unaligned_byte_slice_writer_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.push    (push),
		.tile    (tile),
		.full    (full),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

	always #6 clk = ~clk;

	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int pick_extent();
		case ($urandom_range(0, 2))
			0: return $urandom_range(1, 8);
			1: return $urandom_range(1, 65535);
			default: return 65535;
		endcase
	endfunction

	task automatic emit_word(input logic [31:0] addr, input int lo, input int count,
			input logic [63:0] data, input bit fin);
		result_t r;
		int n;
		logic [63:0] keep;
		n = (count > WORD_BYTES - lo) ? WORD_BYTES - lo : count;
		r = '0;
		keep = '0;
		r.word_address = addr;
		r.to_scratch = (dst_bank == 8'(SCRATCH_BANK));
		r.bank_out = dst_bank;
		for (int i = 0; i < WORD_BYTES; i++) begin
			if (i >= lo && i < lo + n) begin
				r.byte_enable[i] = 1'b1;
				keep[i*BYTE_BITS +: BYTE_BITS] = '1;
			end
		end
		r.write_data = data & keep;
		r.last = fin;
		expected_writes.push_back(r);
	endtask

	task automatic predict_writes(input tile_t t);
		result_t refused;
		logic [16:0] chan_end;
		logic [63:0] prod;
		logic [31:0] pix;
		logic [31:0] phys;
		logic [31:0] start;
		logic [31:0] word0;
		int lanes;
		int lo;
		int head;
		lanes = int'(t.lane_count);
		chan_end = 17'(t.channel_begin) + 17'(t.lane_count);
		if (lanes == 0 || lanes > MAX_LANES || t.row >= dst_height || t.col >= dst_width ||
				chan_end > 17'(dst_channels)) begin
			refused = '0;
			refused.rejected = 1'b1;
			refused.last = 1'b1;
			expected_writes.push_back(refused);
		end else begin
			phys = (dst_phys == 16'd0) ? 32'(dst_channels) : 32'(dst_phys);
			prod = 64'(t.row) * 64'(dst_width) + 64'(t.col);
			pix = prod[31:0];
			prod = 64'(pix) * 64'(phys);
			start = dst_base + prod[31:0] + 32'(dst_offset) + 32'(t.channel_begin);
			lo = int'(start % 32'(WORD_BYTES));
			word0 = start - 32'(lo);
			head = (lo + lanes <= WORD_BYTES) ? lanes : WORD_BYTES - lo;
			emit_word(word0, lo, head, t.packed_data << (lo * BYTE_BITS), head >= lanes);
			// spill into the following word, wraps at the top of the address space
			if (head < lanes)
				emit_word(word0 + 32'(WORD_BYTES), 0, lanes - head,
					t.packed_data >> (head * BYTE_BITS), 1'b1);
		end
	endtask

	task automatic field_diff(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v)
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(4 * int'(idx));
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_BASE:     dst_base = value;
			REG_HEIGHT:   dst_height = value[15:0];
			REG_WIDTH:    dst_width = value[15:0];
			REG_CHANNELS: dst_channels = value[15:0];
			REG_PHYS:     dst_phys = value[15:0];
			REG_OFFSET:   dst_offset = value[15:0];
			REG_BANK:     dst_bank = value[7:0];
			default: ;
		endcase
	endtask

	task automatic set_dest(input logic [31:0] base, input int h, input int w, input int ch,
			input int ph, input int off, input int bank);
		write_reg(REG_BASE, base);
		write_reg(REG_HEIGHT, 32'(h));
		write_reg(REG_WIDTH, 32'(w));
		write_reg(REG_CHANNELS, 32'(ch));
		write_reg(REG_PHYS, 32'(ph));
		write_reg(REG_OFFSET, 32'(off));
		write_reg(REG_BANK, 32'(bank));
	endtask

	task automatic randomize_dest();
		int ch;
		int ph;
		ch = ($urandom_range(0, 3) == 0) ? pick_extent() : int'($urandom_range(1, 40));
		case ($urandom_range(0, 2))
			0: ph = 0;
			1: ph = (ch + int'($urandom_range(0, 8))) & 16'hFFFF;
			default: ph = int'($urandom_range(0, 65535));
		endcase
		set_dest(($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15) : $urandom,
			pick_extent(), pick_extent(), ch, ph,
			$urandom_range(0, 1) ? int'($urandom_range(0, 65535)) : int'($urandom_range(0, 7)),
			($urandom_range(0, 3) == 0) ? SCRATCH_BANK : int'($urandom_range(0, 255)));
	endtask

	task automatic add_tile(input int r, input int c, input int cb, input int lanes,
			input logic [63:0] data);
		tile_t t;
		t.row = 16'(r);
		t.col = 16'(c);
		t.channel_begin = 16'(cb);
		t.lane_count = 8'(lanes);
		t.packed_data = data;
		pending_tiles.push_back(t);
	endtask

	// in-bounds tile when asked and the tensor allows one, else anything
	task automatic make_tile(input bit sane, output tile_t t);
		int h;
		int w;
		int ch;
		int lanes_max;
		h = int'(dst_height);
		w = int'(dst_width);
		ch = int'(dst_channels);
		t.packed_data = {$urandom, $urandom};
		if (sane && h != 0 && w != 0 && ch != 0) begin
			lanes_max = (ch < MAX_LANES) ? ch : MAX_LANES;
			t.lane_count = 8'($urandom_range(1, lanes_max));
			t.row = 16'($urandom_range(0, h - 1));
			t.col = 16'($urandom_range(0, w - 1));
			t.channel_begin = 16'($urandom_range(0, ch - int'(t.lane_count)));
		end else begin
			t.row = 16'($urandom);
			t.col = 16'($urandom);
			t.channel_begin = 16'($urandom);
			t.lane_count = 8'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 9));
		end
	endtask

	task automatic drain();
		while (pending_tiles.size() != 0 || push || expected_writes.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				predict_writes(tile);
			if (!push || !full) begin
				if (tx_gap > 0) begin
					tx_gap--;
					push <= 1'b0;
				end else if (pending_tiles.size() != 0) begin
					tile <= pending_tiles.pop_front();
					push <= 1'b1;
					tx_gap = pick_gap(tx_calm);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_writes.size() == 0) begin
					errors++;
					if (errors <= 20)
						$display("%0t: expected nothing, actual %p", $time, result);
				end else begin
					want = expected_writes.pop_front();
					if (result !== want) begin
						errors++;
						if (errors <= 20) begin
							field_diff("rejected", 64'(want.rejected), 64'(result.rejected));
							field_diff("word_address", 64'(want.word_address),
								64'(result.word_address));
							field_diff("to_scratch", 64'(want.to_scratch),
								64'(result.to_scratch));
							field_diff("bank_out", 64'(want.bank_out), 64'(result.bank_out));
							field_diff("byte_enable", 64'(want.byte_enable),
								64'(result.byte_enable));
							field_diff("write_data", want.write_data, result.write_data);
							field_diff("last", 64'(want.last), 64'(result.last));
						end
					end
				end
				rx_gap = pick_gap(rx_calm);
			end
			if (hold_seen != hold_req) begin
				hold_seen++;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		#12_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		tile_t t;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		push = 1'b0;
		tile = '0;
		pop = 1'b0;
		dst_base = '0;
		dst_height = '0;
		dst_width = '0;
		dst_channels = '0;
		dst_phys = '0;
		dst_offset = '0;
		dst_bank = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty tensor after reset: everything bounces
		add_tile(0, 0, 0, 1, 64'h0);
		add_tile(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, '1);
		drain();

		set_dest(32'h0000_0003, 4, 5, 20, 0, 2, SCRATCH_BANK);
		add_tile(0, 0, 0, 0, 64'h0123_4567_89AB_CDEF);
		add_tile(0, 0, 0, 9, 64'h0123_4567_89AB_CDEF);
		add_tile(4, 0, 0, 1, 64'h0123_4567_89AB_CDEF);
		add_tile(0, 5, 0, 1, 64'h0123_4567_89AB_CDEF);
		add_tile(3, 4, 13, 8, 64'h0123_4567_89AB_CDEF);
		add_tile(3, 4, 12, 8, 64'hFEDC_BA98_7654_3210);
		add_tile(0, 0, 0, 1, '1);
		add_tile(0, 1, 0, 8, 64'hA5A5_5A5A_0F0F_F0F0);
		add_tile(0, 0, 3, 5, '1);
		add_tile(0, 0, 11, 8, 64'h1122_3344_5566_7788);
		drain();

		// everything at its top value, addresses wrap
		set_dest(32'hFFFF_FFFF, 65535, 65535, 65535, 65535, 65535, 255);
		add_tile(16'hFFFE, 16'hFFFE, 16'hFFF7, 8, 64'hDEAD_BEEF_CAFE_F00D);
		add_tile(0, 0, 0, 8, '1);
		add_tile(16'hFFFF, 0, 0, 1, '1);
		add_tile(0, 16'hFFFF, 0, 1, '1);
		add_tile(0, 0, 0, 8'hFF, '1);
		drain();

		// explicit pixel stride, second word lands on address zero
		set_dest(32'hFFFF_FFF8, 2, 2, 8, 16, 4, 0);
		add_tile(0, 0, 0, 8, 64'h8877_6655_4433_2211);
		add_tile(1, 1, 0, 8, '1);
		add_tile(1, 0, 7, 1, '1);
		drain();

		for (int p = 0; p < 8; p++) begin
			tx_calm = (p == 2);
			rx_calm = (p == 2 || p == 5);
			randomize_dest();
			for (int k = 0; k < 188; k++) begin
				make_tile($urandom_range(0, 99) < 85, t);
				pending_tiles.push_back(t);
			end
			drain();
		end

		// output side stalls for a long stretch while tiles keep coming
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		set_dest($urandom, 64, 64, 24, 0, int'($urandom_range(0, 65535)),
			int'($urandom_range(0, 255)));
		hold_req++;
		for (int k = 0; k < 50; k++) begin
			make_tile(1'b1, t);
			pending_tiles.push_back(t);
		end
		drain();

		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== unaligned_byte_slice_writer_unit.f =====
design/ubsw_pkg.sv
design/ubsw_front.sv
design/ubsw_queue.sv
design/ubsw_back.sv
design/unaligned_byte_slice_writer_unit.sv
bench/unaligned_byte_slice_writer_unit_tb.sv
